### src/ipv6_extension_chain_walker_top_defines.svh
// Assertion macros for the extension chain walker.
`ifndef IPV6_EXTENSION_CHAIN_WALKER_TOP_DEFINES_SVH
`define IPV6_EXTENSION_CHAIN_WALKER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define IECW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define IECW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/iecw_pkg.sv
`timescale 1ns / 1ps

package iecw_pkg;

   localparam int IECW_POSITION_BITS = 16;

   localparam int          FIXED_LEN       = 40;
   localparam int          NEXT_HDR_OFFSET = 6;
   localparam logic [7:0]  FRAG_TYPE       = 8'd44;
   localparam logic [3:0]  MAX_EXT_RESET   = 4'd10;

   localparam logic [7:0]  EXT_HOP_BY_HOP  = 8'd0;
   localparam logic [7:0]  EXT_ROUTING     = 8'd43;
   localparam logic [7:0]  EXT_ESP         = 8'd50;
   localparam logic [7:0]  EXT_AUTH        = 8'd51;
   localparam logic [7:0]  EXT_DEST_OPTS   = 8'd60;
   localparam logic [7:0]  EXT_MOBILITY    = 8'd135;

   // Register index on the configuration port
   localparam logic REG_HDR_LIMIT = 1'b0;

   typedef enum logic [2:0] {
      PH_FIXED    = 3'd0,
      PH_EXT_HEAD = 3'd1,
      PH_EXT_LEN  = 3'd2,
      PH_BODY     = 3'd3,
      PH_DONE     = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_TRUNC = 2'd2,
      ST_LIMIT = 2'd3
   } status_type;

   function automatic logic is_ext_type(input logic [7:0] t);
      return (t == EXT_HOP_BY_HOP) || (t == EXT_ROUTING) || (t == FRAG_TYPE) ||
             (t == EXT_ESP) || (t == EXT_AUTH) || (t == EXT_DEST_OPTS) ||
             (t == EXT_MOBILITY);
   endfunction

endpackage

### src/ipv6_extension_chain_walker_top.sv
`timescale 1ns / 1ps
// IPv6 extension header chain walker.
//
// Input channel (req_): one packet byte per beat, starting at the first byte
// of the fixed 40-byte header; req_last_byte marks the final byte.
// Result channel (rsp_): one beat per packet, issued for the last byte:
// status, bytes consumed, final protocol and number of extension headers.
// Configuration: one APB register at byte address 0, the extension header
// limit (4 bits, reset 10). Write it only while no packet is in flight.
//
// Throughput: one byte per cycle while req_stall is low. Each byte does one
// compare and one add on the walk state, then the walk state register updates.
// Output: the result beat appears on rsp_ in the cycle after the last byte is
// accepted.
// Reset (synchronous): walk state returns to the fixed header phase, the
// result register empties and the limit register goes to 10.
// Stall: while rsp_stall holds a waiting result, req_stall rises and the
// result register holds; otherwise bytes keep flowing while a result waits
// to be taken.
module ipv6_extension_chain_walker_top
   import iecw_pkg::*;
#(
   parameter int POSITION_BITS = IECW_POSITION_BITS
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_bytes_consumed,
   output logic [7:0]  rsp_final_protocol,
   output logic [3:0]  rsp_ext_headers_seen,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Wide enough for header start plus (255 + 1) * 8 without overflow
   localparam int END_BITS = POSITION_BITS + 12;

   // ---------------------------------------------------------------- config
   logic [3:0] max_ext_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ext_ff <= MAX_EXT_RESET;
      end else if (csr_write && (csr_paddr[2] == REG_HDR_LIMIT)) begin
         max_ext_ff <= csr_pwdata[3:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_HDR_LIMIT) begin
         csr_prdata = {28'd0, max_ext_ff};
      end
   end

   // ------------------------------------------------------------ walk state
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [7:0]               base_nh_ff, base_nh_in;
   logic [7:0]               cur_type_ff, cur_type_in;
   logic [7:0]               pend_type_ff, pend_type_in;
   logic [POSITION_BITS-1:0] hdr_start_ff, hdr_start_in;
   logic [POSITION_BITS-1:0] hdr_end_ff, hdr_end_in;
   logic [3:0]               ext_cnt_ff, ext_cnt_in;
   phase_type                phase_ff, phase_in;

   logic                     req_accept;
   logic                     rsp_take;

   // Result of the current byte, loaded into the result register on last
   status_type               res_status;
   logic [15:0]              res_consumed;
   logic [7:0]               res_proto;
   logic [3:0]               res_seen;

   logic [END_BITS-1:0]      frag_end_wide;
   logic [END_BITS-1:0]      len_end_wide;
   logic [POSITION_BITS:0]   pos_plus_one;
   logic [3:0]               cnt_plus_one;
   logic [POSITION_BITS+15:0] hdr_start_ext;

   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic [15:0]              rsp_consumed_ff;
   logic [7:0]               rsp_proto_ff;
   logic [3:0]               rsp_seen_ff;

   // Take a new byte unless a finished result is stuck in the result register
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Candidate header ends; an end past the position range clips to zero so
   // the body compare never fires and the packet reports truncation.
   assign frag_end_wide = END_BITS'(hdr_start_ff) + END_BITS'(8);
   assign len_end_wide  = END_BITS'(hdr_start_ff) +
                          END_BITS'({({1'b0, req_data_byte} + 9'd1), 3'b000});
   assign pos_plus_one  = {1'b0, pos_ff} + 1'b1;
   assign cnt_plus_one  = ext_cnt_ff + 4'd1;

   always_comb begin
      pos_in       = pos_ff;
      base_nh_in   = base_nh_ff;
      cur_type_in  = cur_type_ff;
      pend_type_in = pend_type_ff;
      hdr_start_in = hdr_start_ff;
      hdr_end_in   = hdr_end_ff;
      ext_cnt_in   = ext_cnt_ff;
      phase_in     = phase_ff;

      unique case (phase_ff)
         PH_FIXED: begin
            // Capture the next-header byte of the fixed header
            if (pos_ff == POSITION_BITS'(NEXT_HDR_OFFSET)) begin
               base_nh_in  = req_data_byte;
               cur_type_in = req_data_byte;
            end
            if (pos_ff == POSITION_BITS'(FIXED_LEN - 1)) begin
               hdr_start_in = POSITION_BITS'(FIXED_LEN);
               phase_in = (is_ext_type(cur_type_ff) && (ext_cnt_ff < max_ext_ff)) ?
                          PH_EXT_HEAD : PH_DONE;
            end
         end
         PH_EXT_HEAD: begin
            pend_type_in = req_data_byte;
            if (cur_type_ff == FRAG_TYPE) begin
               hdr_end_in = (frag_end_wide[END_BITS-1:POSITION_BITS] != '0) ?
                            '0 : frag_end_wide[POSITION_BITS-1:0];
            end
            phase_in = PH_EXT_LEN;
         end
         PH_EXT_LEN: begin
            if (cur_type_ff != FRAG_TYPE) begin
               hdr_end_in = (len_end_wide[END_BITS-1:POSITION_BITS] != '0) ?
                            '0 : len_end_wide[POSITION_BITS-1:0];
            end
            phase_in = PH_BODY;
         end
         PH_BODY: begin
            // Last byte of this header: advance to the next one in the chain
            if (pos_plus_one == {1'b0, hdr_end_ff}) begin
               ext_cnt_in   = cnt_plus_one;
               cur_type_in  = pend_type_ff;
               hdr_start_in = hdr_end_ff;
               phase_in = (is_ext_type(pend_type_ff) && (cnt_plus_one < max_ext_ff)) ?
                          PH_EXT_HEAD : PH_DONE;
            end
         end
         default: begin
            // Done, and any unused code: hold
         end
      endcase

      // Saturating position
      if (pos_ff != '1) begin
         pos_in = pos_plus_one[POSITION_BITS-1:0];
      end
   end

   assign hdr_start_ext = {16'd0, hdr_start_in};

   always_comb begin
      if (phase_in == PH_FIXED) begin
         res_status   = ST_SHORT;
         res_consumed = '0;
         res_proto    = '0;
         res_seen     = '0;
      end else if ((phase_in == PH_EXT_LEN) || (phase_in == PH_BODY)) begin
         res_status   = ST_TRUNC;
         res_consumed = hdr_start_ext[15:0];
         res_proto    = base_nh_in;
         res_seen     = ext_cnt_in;
      end else begin
         res_status   = (ext_cnt_in >= max_ext_ff) ? ST_LIMIT : ST_OK;
         res_consumed = hdr_start_ext[15:0];
         res_proto    = cur_type_in;
         res_seen     = ext_cnt_in;
      end
   end

   // State register: clear for the next packet after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         base_nh_ff   <= '0;
         cur_type_ff  <= '0;
         pend_type_ff <= '0;
         hdr_start_ff <= '0;
         hdr_end_ff   <= '0;
         ext_cnt_ff   <= '0;
         phase_ff     <= PH_FIXED;
      end else if (req_accept) begin
         if (req_last_byte) begin
            pos_ff       <= '0;
            base_nh_ff   <= '0;
            cur_type_ff  <= '0;
            pend_type_ff <= '0;
            hdr_start_ff <= '0;
            hdr_end_ff   <= '0;
            ext_cnt_ff   <= '0;
            phase_ff     <= PH_FIXED;
         end else begin
            pos_ff       <= pos_in;
            base_nh_ff   <= base_nh_in;
            cur_type_ff  <= cur_type_in;
            pend_type_ff <= pend_type_in;
            hdr_start_ff <= hdr_start_in;
            hdr_end_ff   <= hdr_end_in;
            ext_cnt_ff   <= ext_cnt_in;
            phase_ff     <= phase_in;
         end
      end
   end

   // ------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && req_last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_last_byte) begin
         rsp_status_ff   <= res_status;
         rsp_consumed_ff <= res_consumed;
         rsp_proto_ff    <= res_proto;
         rsp_seen_ff     <= res_seen;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_bytes_consumed   = rsp_consumed_ff;
   assign rsp_final_protocol   = rsp_proto_ff;
   assign rsp_ext_headers_seen = rsp_seen_ff;

   // ------------------------------------------------------------ assertions
`include "ipv6_extension_chain_walker_top_defines.svh"

   `IECW_ASSERT_NEXT(a_last_clears_walk, req_accept && req_last_byte,
      rsp_valid_ff && (phase_ff == PH_FIXED) && (pos_ff == '0),
      "last byte did not produce a result and clear the walk")
   `IECW_ASSERT_NOW(a_walk_after_fixed, phase_ff != PH_FIXED,
      pos_ff >= POSITION_BITS'(FIXED_LEN),
      "chain walk started before the fixed header ended")
   `IECW_ASSERT_NOW(a_short_is_empty, rsp_valid_ff && (rsp_status_ff == ST_SHORT),
      (rsp_consumed_ff == '0) && (rsp_proto_ff == '0) && (rsp_seen_ff == '0),
      "short packet result carries nonzero fields")
   `IECW_ASSERT_NEXT(a_held_result, rsp_valid_ff && rsp_stall,
      rsp_valid_ff && $stable(rsp_consumed_ff) && $stable(rsp_status_ff),
      "stalled result changed or vanished")

endmodule
